/* sv/asv_pkg.sv */
// asv_pkg: types, codes and helpers shared by the square-wave voice.
// No dependencies.
package asv_pkg;

   localparam int PHASE_BITS_DEF    = 32;
   localparam int AMP_FRAC_BITS_DEF = 30;
   localparam int DEN_W             = 24;
   localparam int DUR_W             = 18;
   localparam int GAIN_W            = 16;
   localparam int CSR_W             = 18;
   localparam int VEL_W             = 7;
   localparam logic [DEN_W-1:0] VEL_DEN = 24'd10241915;
   localparam logic [GAIN_W-1:0] GAIN_UNITY = 16'd32768;

   localparam logic [2:0] ACT_TICK    = 3'd0;
   localparam logic [2:0] ACT_NOTE_ON = 3'd1;
   localparam logic [2:0] ACT_RELEASE = 3'd2;
   localparam logic [2:0] ACT_FAST    = 3'd3;
   localparam logic [2:0] ACT_KILL    = 3'd4;

   localparam logic [2:0] CSR_VOLUME  = 3'd0;
   localparam logic [2:0] CSR_SUSTAIN = 3'd1;
   localparam logic [2:0] CSR_ATTACK  = 3'd2;
   localparam logic [2:0] CSR_DECAY   = 3'd3;
   localparam logic [2:0] CSR_RELEASE = 3'd4;
   localparam logic [2:0] CSR_FAST    = 3'd5;

   typedef enum logic [2:0] {
      STG_IDLE, STG_ATTACK, STG_DECAY, STG_RELEASE, STG_FAST
   } stage_type;

   typedef enum logic [3:0] {
      SEQ_IDLE, SEQ_EXEC, SEQ_PEAK, SEQ_HOLD, SEQ_RISE,
      SEQ_FALL, SEQ_REL, SEQ_STEAL, SEQ_TREL, SEQ_MUL, SEQ_OUT
   } seq_type;

   function automatic logic [DUR_W-1:0] dur(input logic [DUR_W-1:0] d);
      return (d == '0) ? DUR_W'(1) : d;
   endfunction

   function automatic logic [GAIN_W-1:0] gain(input logic [GAIN_W-1:0] g);
      return (g > GAIN_UNITY) ? GAIN_UNITY : g;
   endfunction

endpackage

/* sv/asv_div.sv */
// asv_div: restoring divider, one quotient bit per cycle.
// Depends on nothing.
module asv_div #(
   parameter int NW = 52,
   parameter int DW = 24
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  logic [NW-1:0] num,
   input  logic [DW-1:0] den,
   output logic          done,
   output logic [NW-1:0] quot
);
   localparam int CW = $clog2(NW + 1);

   logic [NW-1:0] q_ff, q_in;
   logic [DW-1:0] r_ff, r_in, d_ff, d_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic          busy_ff, busy_in, done_ff, done_in;

   always_comb begin
      logic [DW:0] trial;
      logic        qb;
      q_in = q_ff;
      r_in = r_ff;
      d_in = d_ff;
      cnt_in = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial = {r_ff, q_ff[NW-1]};
      qb = trial >= {1'b0, d_ff};
      if (start) begin
         q_in = num;
         r_in = '0;
         d_in = den;
         cnt_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         r_in = qb ? DW'(trial - {1'b0, d_ff}) : trial[DW-1:0];
         q_in = {q_ff[NW-2:0], qb};
         cnt_in = cnt_ff + CW'(1);
         if (cnt_ff == CW'(NW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
      r_ff <= r_in;
      d_ff <= d_in;
   end

   assign done = done_ff;
   assign quot = q_ff;
endmodule

/* sv/adsr_square_voice.sv */
// adsr_square_voice: one voice, four-stage envelope on a square oscillator.
// Depends on asv_pkg and asv_div.
//
// One request is taken at a time and produces one response. A tick while
// idle and any release, fast release, kill or unused action go straight
// to the output; an active tick first scales the amplitude by the volume,
// and a tick that steps the decay also recomputes the release slope. A
// note-on looks up the peak, derives the hold level and then the attack,
// decay, release and fast slopes. Divisions by the duration registers go
// through one shared bit-serial divider, one quotient bit per cycle; the
// velocity peak comes from a constant table. A finished response is held
// in an output register, so the next request is accepted while it waits.
module adsr_square_voice #(
   parameter int PHASE_BITS    = asv_pkg::PHASE_BITS_DEF,
   parameter int AMP_FRAC_BITS = asv_pkg::AMP_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [2:0]                     req_action,
   input  logic [6:0]                     req_velocity,
   input  logic [31:0]                    req_phase_step,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [23:0]             rsp_sample,
   output logic                           rsp_note_ended,
   output logic                           rsp_active,
   input  logic                           csr_we,
   input  logic [2:0]                     csr_index,
   input  logic [asv_pkg::CSR_W-1:0]      csr_wdata
);
   localparam int AW = AMP_FRAC_BITS + 1;
   localparam int NW = AW + 1;
   localparam int PW = AW + asv_pkg::GAIN_W;
   localparam int MW = PW - (AMP_FRAC_BITS - 8);
   localparam int DW = asv_pkg::DEN_W;
   localparam int UW = asv_pkg::DUR_W;
   localparam int GW = asv_pkg::GAIN_W;
   localparam int VN = 1 << asv_pkg::VEL_W;

   logic [GW-1:0] vol_ff, sus_ff;
   logic [UW-1:0] att_ff, dec_ff, rel_ff, fst_ff;

   asv_pkg::seq_type   seq_ff, seq_in;
   asv_pkg::stage_type stage_ff, stage_in;
   logic [PHASE_BITS-1:0] phase_ff, phase_in, inc_ff, inc_in, inc_scaled;
   logic [AW-1:0] amp_ff, amp_in, peak_ff, peak_in, hold_ff, hold_in;
   logic [AW-1:0] rise_ff, rise_in, fall_ff, fall_in, rstep_ff, rstep_in;
   logic [AW-1:0] steal_ff, steal_in;
   logic [2:0]    act_ff, act_in;
   logic [6:0]    vel_ff, vel_in;
   logic [31:0]   pstep_ff, pstep_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic          live_ff, live_in, ended_ff, ended_in, run_ff, run_in;
   logic          rsp_valid_ff, rsp_valid_in, rsp_ended_ff, rsp_ended_in;
   logic          rsp_active_ff, rsp_active_in;
   logic [23:0]   rsp_sample_ff, rsp_sample_in;

   logic          div_start, div_done;
   logic [NW-1:0] div_num, div_quot;
   logic [DW-1:0] div_den;

   logic [AW-1:0] peak_tab [VN];

   asv_div #(.NW(NW), .DW(DW)) u_div (
      .clock(clock), .reset(reset), .start(div_start), .num(div_num),
      .den(div_den), .done(div_done), .quot(div_quot)
   );

   // peak level per velocity: 2*v^3 * 2^AMP_FRAC_BITS / (5*127^3)
   genvar gi;
   for (gi = 0; gi < VN; gi = gi + 1) begin : g_peak
      localparam logic [63:0] CUBE2 = 64'(2 * gi * gi * gi);
      assign peak_tab[gi] = AW'((CUBE2 << AMP_FRAC_BITS) / 64'(asv_pkg::VEL_DEN));
   end

   if (PHASE_BITS >= 32) begin : g_up
      assign inc_scaled = PHASE_BITS'(pstep_ff) << (PHASE_BITS - 32);
   end else begin : g_dn
      assign inc_scaled = PHASE_BITS'(pstep_ff >> (32 - PHASE_BITS));
   end

   always_comb begin
      logic [AW-1:0] a;
      logic [MW-1:0] mag;
      logic [23:0]   smp;
      logic          pos;
      seq_in = seq_ff;
      stage_in = stage_ff;
      phase_in = phase_ff;
      inc_in = inc_ff;
      amp_in = amp_ff;
      peak_in = peak_ff;
      hold_in = hold_ff;
      rise_in = rise_ff;
      fall_in = fall_ff;
      rstep_in = rstep_ff;
      steal_in = steal_ff;
      act_in = act_ff;
      vel_in = vel_ff;
      pstep_in = pstep_ff;
      prod_in = prod_ff;
      live_in = live_ff;
      ended_in = ended_ff;
      run_in = run_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      rsp_sample_in = rsp_sample_ff;
      rsp_ended_in = rsp_ended_ff;
      rsp_active_in = rsp_active_ff;
      div_start = 1'b0;
      div_num = '0;
      div_den = DW'(1);
      a = amp_ff;
      req_stall = seq_ff != asv_pkg::SEQ_IDLE;

      mag = prod_ff[PW-1:AMP_FRAC_BITS-8];
      if (mag > MW'(24'h7FFFFF)) mag = MW'(24'h7FFFFF);
      pos = (phase_ff != '0) && !phase_ff[PHASE_BITS-1];
      smp = pos ? mag[23:0] : (~mag[23:0] + 24'd1);

      unique case (seq_ff)
         asv_pkg::SEQ_REL, asv_pkg::SEQ_STEAL, asv_pkg::SEQ_RISE,
         asv_pkg::SEQ_FALL, asv_pkg::SEQ_TREL: begin
            div_start = !run_ff;
            run_in = 1'b1;
         end
         default: ;
      endcase

      unique case (seq_ff)
         asv_pkg::SEQ_IDLE: begin
            if (req_valid) begin
               act_in = req_action;
               vel_in = req_velocity;
               pstep_in = req_phase_step;
               seq_in = asv_pkg::SEQ_EXEC;
            end
         end
         asv_pkg::SEQ_EXEC: begin
            live_in = 1'b0;
            ended_in = 1'b0;
            seq_in = asv_pkg::SEQ_OUT;
            unique case (act_ff)
               asv_pkg::ACT_TICK: begin
                  live_in = stage_ff != asv_pkg::STG_IDLE;
                  if (stage_ff != asv_pkg::STG_IDLE) seq_in = asv_pkg::SEQ_MUL;
                  unique case (stage_ff)
                     asv_pkg::STG_ATTACK: begin
                        if (amp_ff < peak_ff) begin
                           a = amp_ff + rise_ff;
                           amp_in = a;
                           if (a >= peak_ff) stage_in = asv_pkg::STG_DECAY;
                        end
                     end
                     asv_pkg::STG_DECAY: begin
                        if (amp_ff >= hold_ff) begin
                           amp_in = (amp_ff > fall_ff) ? amp_ff - fall_ff : '0;
                           seq_in = asv_pkg::SEQ_TREL;
                        end
                     end
                     asv_pkg::STG_RELEASE, asv_pkg::STG_FAST: begin
                        if (amp_ff != '0) begin
                           a = (stage_ff == asv_pkg::STG_RELEASE) ? rstep_ff : steal_ff;
                           a = (amp_ff > a) ? amp_ff - a : '0;
                        end
                        amp_in = a;
                        if (a == '0) begin
                           ended_in = 1'b1;
                           stage_in = asv_pkg::STG_IDLE;
                        end
                     end
                     default: ;
                  endcase
               end
               asv_pkg::ACT_NOTE_ON: begin
                  phase_in = '0;
                  amp_in = '0;
                  inc_in = inc_scaled;
                  seq_in = asv_pkg::SEQ_PEAK;
               end
               asv_pkg::ACT_RELEASE: begin
                  if (stage_ff == asv_pkg::STG_ATTACK || stage_ff == asv_pkg::STG_DECAY)
                     stage_in = asv_pkg::STG_RELEASE;
               end
               asv_pkg::ACT_FAST: begin
                  if (stage_ff != asv_pkg::STG_IDLE) stage_in = asv_pkg::STG_FAST;
               end
               asv_pkg::ACT_KILL: begin
                  stage_in = asv_pkg::STG_IDLE;
                  amp_in = '0;
               end
               default: ;
            endcase
         end
         asv_pkg::SEQ_PEAK: begin
            peak_in = peak_tab[vel_ff];
            seq_in = asv_pkg::SEQ_HOLD;
         end
         asv_pkg::SEQ_HOLD: begin
            hold_in = AW'((PW'(peak_ff) * PW'(asv_pkg::gain(sus_ff))) >> 15);
            seq_in = asv_pkg::SEQ_RISE;
         end
         asv_pkg::SEQ_RISE: begin
            div_num = NW'(peak_ff) + NW'(asv_pkg::dur(att_ff)) - NW'(1);
            div_den = DW'(asv_pkg::dur(att_ff));
            if (div_done) begin
               rise_in = div_quot[AW-1:0];
               run_in = 1'b0;
               seq_in = asv_pkg::SEQ_FALL;
            end
         end
         asv_pkg::SEQ_FALL: begin
            div_num = NW'(peak_ff - hold_ff) + NW'(asv_pkg::dur(dec_ff)) - NW'(1);
            div_den = DW'(asv_pkg::dur(dec_ff));
            if (div_done) begin
               fall_in = div_quot[AW-1:0];
               run_in = 1'b0;
               seq_in = asv_pkg::SEQ_REL;
            end
         end
         asv_pkg::SEQ_REL: begin
            div_num = NW'(peak_ff) + NW'(asv_pkg::dur(rel_ff)) - NW'(1);
            div_den = DW'(asv_pkg::dur(rel_ff));
            if (div_done) begin
               rstep_in = div_quot[AW-1:0];
               run_in = 1'b0;
               seq_in = asv_pkg::SEQ_STEAL;
            end
         end
         asv_pkg::SEQ_STEAL: begin
            div_num = NW'(peak_ff) + NW'(asv_pkg::dur(fst_ff)) - NW'(1);
            div_den = DW'(asv_pkg::dur(fst_ff));
            if (div_done) begin
               steal_in = div_quot[AW-1:0];
               run_in = 1'b0;
               stage_in = asv_pkg::STG_ATTACK;
               seq_in = asv_pkg::SEQ_OUT;
            end
         end
         asv_pkg::SEQ_TREL: begin
            div_num = NW'(amp_ff) + NW'(asv_pkg::dur(rel_ff)) - NW'(1);
            div_den = DW'(asv_pkg::dur(rel_ff));
            if (div_done) begin
               rstep_in = div_quot[AW-1:0];
               run_in = 1'b0;
               seq_in = asv_pkg::SEQ_MUL;
            end
         end
         asv_pkg::SEQ_MUL: begin
            prod_in = amp_ff * asv_pkg::gain(vol_ff);
            seq_in = asv_pkg::SEQ_OUT;
         end
         asv_pkg::SEQ_OUT: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_sample_in = (live_ff && !ended_ff) ? smp : 24'd0;
               rsp_ended_in = ended_ff;
               rsp_active_in = stage_ff != asv_pkg::STG_IDLE;
               if (live_ff) phase_in = phase_ff + inc_ff;
               seq_in = asv_pkg::SEQ_IDLE;
            end
         end
         default: seq_in = asv_pkg::SEQ_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seq_ff <= asv_pkg::SEQ_IDLE;
         stage_ff <= asv_pkg::STG_IDLE;
         run_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         phase_ff <= '0;
         inc_ff <= '0;
         amp_ff <= '0;
         peak_ff <= '0;
         hold_ff <= '0;
         rise_ff <= '0;
         fall_ff <= '0;
         rstep_ff <= '0;
         steal_ff <= '0;
         vol_ff <= asv_pkg::GAIN_UNITY;
         sus_ff <= GW'(16384);
         att_ff <= UW'(480);
         dec_ff <= UW'(36000);
         rel_ff <= UW'(36000);
         fst_ff <= UW'(240);
      end else begin
         seq_ff <= seq_in;
         stage_ff <= stage_in;
         run_ff <= run_in;
         rsp_valid_ff <= rsp_valid_in;
         phase_ff <= phase_in;
         inc_ff <= inc_in;
         amp_ff <= amp_in;
         peak_ff <= peak_in;
         hold_ff <= hold_in;
         rise_ff <= rise_in;
         fall_ff <= fall_in;
         rstep_ff <= rstep_in;
         steal_ff <= steal_in;
         if (csr_we) begin
            unique case (csr_index)
               asv_pkg::CSR_VOLUME:  vol_ff <= csr_wdata[GW-1:0];
               asv_pkg::CSR_SUSTAIN: sus_ff <= csr_wdata[GW-1:0];
               asv_pkg::CSR_ATTACK:  att_ff <= csr_wdata[UW-1:0];
               asv_pkg::CSR_DECAY:   dec_ff <= csr_wdata[UW-1:0];
               asv_pkg::CSR_RELEASE: rel_ff <= csr_wdata[UW-1:0];
               asv_pkg::CSR_FAST:    fst_ff <= csr_wdata[UW-1:0];
               default: ;
            endcase
         end
      end
      act_ff <= act_in;
      vel_ff <= vel_in;
      pstep_ff <= pstep_in;
      prod_ff <= prod_in;
      live_ff <= live_in;
      ended_ff <= ended_in;
      rsp_sample_ff <= rsp_sample_in;
      rsp_ended_ff <= rsp_ended_in;
      rsp_active_ff <= rsp_active_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_sample = rsp_sample_ff;
   assign rsp_note_ended = rsp_ended_ff;
   assign rsp_active = rsp_active_ff;
endmodule

/* bench/tb_adsr_square_voice.sv */
// tb_adsr_square_voice: self-checking bench for the square-wave ADSR voice.
// Depends on asv_pkg and the adsr_square_voice RTL. A behavioral model of the
// envelope and oscillator predicts every response; requests come in bursts.
`timescale 1ns / 1ps

module tb_adsr_square_voice;

   typedef struct packed {
      logic [2:0]  action;
      logic [6:0]  velocity;
      logic [31:0] phase_step;
   } voice_req_type;

   typedef struct packed {
      logic [23:0] sample;
      logic        note_ended;
      logic        active;
   } voice_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [2:0] req_action = '0;
   logic [6:0] req_velocity = '0;
   logic [31:0] req_phase_step = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [23:0] rsp_sample;
   logic rsp_note_ended;
   logic rsp_active;
   logic csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [asv_pkg::CSR_W-1:0] csr_wdata = '0;

   adsr_square_voice u_dut (.*);

   always #5 clock = ~clock;

   // shadow registers and envelope state
   logic [63:0] m_volume, m_sustain, m_attack, m_decay, m_release, m_fast;
   asv_pkg::stage_type m_stage;
   logic [63:0] m_phase, m_inc, m_amp, m_peak, m_hold;
   logic [63:0] m_rise, m_fall, m_rel_step, m_steal;

   voice_req_type pending_reqs[$];
   voice_rsp_type expected_rsps[$];
   int mismatches = 0;
   int n_items = 0;

   function automatic logic [63:0] dur64(logic [63:0] d);
      return (d == 0) ? 64'd1 : d;
   endfunction

   function automatic logic [63:0] clamp_gain(logic [63:0] g);
      return (g > 64'd32768) ? 64'd32768 : g;
   endfunction

   function automatic logic [63:0] div_up(logic [63:0] x, logic [63:0] d);
      return (x + d - 1) / d;
   endfunction

   function automatic logic [63:0] floor_sub(logic [63:0] a, logic [63:0] b);
      return (a > b) ? a - b : 64'd0;
   endfunction

   function automatic voice_rsp_type voice_response(voice_req_type r);
      voice_rsp_type o;
      logic [63:0] mag, st, v;
      logic ended;
      ended = 1'b0;
      o.sample = '0;
      v = 64'(r.velocity);
      case (r.action)
         asv_pkg::ACT_TICK: if (m_stage != asv_pkg::STG_IDLE) begin
            if (m_stage == asv_pkg::STG_ATTACK) begin
               if (m_amp < m_peak) begin
                  m_amp = m_amp + m_rise;
                  if (m_amp >= m_peak) m_stage = asv_pkg::STG_DECAY;
               end
            end else if (m_stage == asv_pkg::STG_DECAY) begin
               if (m_amp >= m_hold) begin
                  m_amp = floor_sub(m_amp, m_fall);
                  m_rel_step = div_up(m_amp, dur64(m_release));
               end
            end else begin
               st = (m_stage == asv_pkg::STG_RELEASE) ? m_rel_step : m_steal;
               if (m_amp != 0) m_amp = floor_sub(m_amp, st);
               if (m_amp == 0) begin
                  ended = 1'b1;
                  m_stage = asv_pkg::STG_IDLE;
               end
            end
            if (!ended) begin
               mag = (m_amp * clamp_gain(m_volume)) >> 22;
               if (mag > 64'd8388607) mag = 64'd8388607;
               o.sample = (m_phase != 0 && m_phase < 64'h8000_0000) ?
                          mag[23:0] : -mag[23:0];
            end
            m_phase = (m_phase + m_inc) & 64'hFFFF_FFFF;
         end
         asv_pkg::ACT_NOTE_ON: begin
            m_phase = 0;
            m_amp = 0;
            m_inc = 64'(r.phase_step);
            m_peak = ((2 * v * v * v) << 30) / 64'd10241915;
            m_hold = (m_peak * clamp_gain(m_sustain)) >> 15;
            m_rise = div_up(m_peak, dur64(m_attack));
            m_fall = div_up(m_peak - m_hold, dur64(m_decay));
            m_rel_step = div_up(m_peak, dur64(m_release));
            m_steal = div_up(m_peak, dur64(m_fast));
            m_stage = asv_pkg::STG_ATTACK;
         end
         asv_pkg::ACT_RELEASE:
            if (m_stage == asv_pkg::STG_ATTACK || m_stage == asv_pkg::STG_DECAY)
               m_stage = asv_pkg::STG_RELEASE;
         asv_pkg::ACT_FAST: if (m_stage != asv_pkg::STG_IDLE) m_stage = asv_pkg::STG_FAST;
         asv_pkg::ACT_KILL: begin
            m_stage = asv_pkg::STG_IDLE;
            m_amp = 0;
         end
         default: ;
      endcase
      o.note_ended = ended;
      o.active = (m_stage != asv_pkg::STG_IDLE);
      return o;
   endfunction

   // request driver: bursts separated by random gaps
   int burst_left = 0;
   int gap_left = 0;
   always @(posedge clock) begin
      voice_req_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsps.push_back(voice_response({req_action, req_velocity, req_phase_step}));
         if (req_valid && req_stall) begin
            // hold the stalled request
         end else if (gap_left > 0) begin
            gap_left <= gap_left - 1;
            req_valid <= 1'b0;
         end else if (pending_reqs.size() > 0) begin
            nxt = pending_reqs.pop_front();
            req_valid <= 1'b1;
            req_action <= nxt.action;
            req_velocity <= nxt.velocity;
            req_phase_step <= nxt.phase_step;
            if (burst_left <= 1) begin
               burst_left <= $urandom_range(1, 20);
               gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 90);
            end else begin
               burst_left <= burst_left - 1;
            end
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response monitor with its own stall pattern
   int stall_phase = 0;
   always @(posedge clock) begin
      voice_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= 10) $display("unexpected response %0d", rsp_sample);
            end else begin
               want = expected_rsps.pop_front();
               if (rsp_sample !== want.sample || rsp_note_ended !== want.note_ended ||
                   rsp_active !== want.active) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("mismatch: exp sample %0d ended %0b active %0b, got %0d %0b %0b",
                              $signed(want.sample), want.note_ended, want.active,
                              rsp_sample, rsp_note_ended, rsp_active);
               end
            end
         end
         stall_phase <= (stall_phase + 1) % 600;
         if (stall_phase < 200) rsp_stall <= 1'b0;
         else if (stall_phase < 400) rsp_stall <= ($urandom_range(0, 3) == 0);
         else rsp_stall <= ($urandom_range(0, 1) == 0);
      end
   end

   task automatic add_req(logic [2:0] act, logic [6:0] vel, logic [31:0] step);
      voice_req_type r;
      r.action = act;
      r.velocity = vel;
      r.phase_step = step;
      pending_reqs.push_back(r);
      n_items++;
   endtask

   task automatic add_ticks(int n);
      repeat (n) add_req(asv_pkg::ACT_TICK, 7'($urandom), $urandom);
   endtask

   task automatic write_reg(logic [2:0] idx, logic [asv_pkg::CSR_W-1:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      case (idx)
         asv_pkg::CSR_VOLUME:  m_volume  = 64'(val[15:0]);
         asv_pkg::CSR_SUSTAIN: m_sustain = 64'(val[15:0]);
         asv_pkg::CSR_ATTACK:  m_attack  = 64'(val);
         asv_pkg::CSR_DECAY:   m_decay   = 64'(val);
         asv_pkg::CSR_RELEASE: m_release = 64'(val);
         asv_pkg::CSR_FAST:    m_fast    = 64'(val);
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_all(logic [15:0] vol, logic [15:0] sus, logic [17:0] att,
                            logic [17:0] dec, logic [17:0] rel, logic [17:0] fst);
      write_reg(asv_pkg::CSR_VOLUME, asv_pkg::CSR_W'(vol));
      write_reg(asv_pkg::CSR_SUSTAIN, asv_pkg::CSR_W'(sus));
      write_reg(asv_pkg::CSR_ATTACK, att);
      write_reg(asv_pkg::CSR_DECAY, dec);
      write_reg(asv_pkg::CSR_RELEASE, rel);
      write_reg(asv_pkg::CSR_FAST, fst);
   endtask

   task automatic drain();
      while (pending_reqs.size() > 0 || expected_rsps.size() > 0 || req_valid)
         @(posedge clock);
      repeat (400) @(posedge clock);
   endtask

   function automatic logic [17:0] pick_dur();
      case ($urandom_range(0, 9))
         0: return 18'd0;
         1: return 18'd1;
         2: return 18'd262143;
         default: return 18'($urandom_range(1, 30));
      endcase
   endfunction

   function automatic logic [15:0] pick_gain();
      case ($urandom_range(0, 5))
         0: return 16'd0;
         1: return 16'd32768;
         2: return 16'hFFFF;
         default: return 16'($urandom);
      endcase
   endfunction

   initial begin
      int ph;
      logic [2:0] a;
      m_volume = 32768; m_sustain = 16384; m_attack = 480; m_decay = 36000;
      m_release = 36000; m_fast = 240;
      m_stage = asv_pkg::STG_IDLE;
      {m_phase, m_inc, m_amp, m_peak, m_hold} = '0;
      {m_rise, m_fall, m_rel_step, m_steal} = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // directed part
      write_all(16'hFFFF, 16'hFFFF, 18'd2, 18'd3, 18'd2, 18'd0);
      add_ticks(1);
      add_req(asv_pkg::ACT_RELEASE, 7'd0, 32'd0);
      add_req(asv_pkg::ACT_FAST, 7'd0, 32'd0);
      add_req(asv_pkg::ACT_NOTE_ON, 7'd127, 32'h8000_0000);
      add_ticks(5);
      add_req(asv_pkg::ACT_RELEASE, 7'd0, 32'd0);
      add_req(asv_pkg::ACT_RELEASE, 7'd0, 32'd0);
      add_ticks(3);
      add_req(asv_pkg::ACT_NOTE_ON, 7'd0, 32'hFFFF_FFFF);
      add_ticks(2);
      add_req(asv_pkg::ACT_FAST, 7'd0, 32'd0);
      add_ticks(2);
      add_req(asv_pkg::ACT_NOTE_ON, 7'd64, 32'h4000_0000);
      add_ticks(2);
      add_req(asv_pkg::ACT_KILL, 7'd0, 32'd0);
      add_req(3'd5, 7'd0, 32'd0);
      add_req(3'd6, 7'h7F, 32'hFFFF_FFFF);
      add_req(3'd7, 7'd0, 32'd0);
      drain();

      // random phases of well-formed notes with some noise
      ph = 0;
      while (n_items < 550) begin
         if (ph == 0)
            write_all(16'd0, 16'd0, 18'd262143, 18'd1, 18'd1, 18'd1);
         else if (ph == 1)
            write_all(16'd32768, 16'd32768, 18'd1, 18'd262143, 18'd0, 18'd262143);
         else
            write_all(pick_gain(), pick_gain(), pick_dur(), pick_dur(), pick_dur(),
                      pick_dur());
         ph++;
         repeat (6) begin
            if (n_items < 550) begin
               if ($urandom_range(0, 4) == 0) begin
                  a = 3'($urandom_range(0, 7));
                  add_req(a, 7'($urandom), $urandom);
               end else begin
                  add_req(asv_pkg::ACT_NOTE_ON, 7'($urandom), $urandom);
                  add_ticks($urandom_range(0, 35));
                  a = ($urandom_range(0, 5) == 0) ? asv_pkg::ACT_KILL :
                      ($urandom_range(0, 2) == 0) ? asv_pkg::ACT_FAST : asv_pkg::ACT_RELEASE;
                  add_req(a, 7'($urandom), $urandom);
                  add_ticks($urandom_range(0, 35));
               end
            end
         end
         drain();
      end

      if (mismatches == 0 && expected_rsps.size() == 0)
         $display("** adsr_square_voice: PASSED **");
      else
         $display("** adsr_square_voice: FAILED **");
      $finish;
   end

   initial begin
      #20ms;
      $display("** adsr_square_voice: FAILED **");
      $finish;
   end

endmodule
